@@ rtl/fph_pkg.sv @@
// Package with shared constants and types for the fixed-point hypotenuse block.
package fph_pkg;
	localparam int MAX_PASSES = 8;
	localparam int PASS_W = $clog2(MAX_PASSES + 1);
	localparam logic [31:0] LIMIT_MAG = 32'h2fffffff;
	localparam logic [31:0] FOUR_FIX = 32'h00040000;
	localparam int DIV_STEPS = 48;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIV1,
		ST_SQ,
		ST_CHK,
		ST_DIV2,
		ST_MUL_A,
		ST_MUL_B,
		ST_DONE
	} state_t;
endpackage

@@ rtl/fph_if.sv @@
// Valid/ready channel interfaces for the hypotenuse block.
interface fph_in_if;
	logic valid;
	logic ready;
	logic signed [31:0] first_value;
	logic signed [31:0] second_value;
	modport source (output valid, first_value, second_value, input ready);
	modport sink (input valid, first_value, second_value, output ready);
endinterface

interface fph_out_if;
	logic valid;
	logic ready;
	logic [30:0] distance;
	logic overflow;
	modport source (output valid, distance, overflow, input ready);
	modport sink (input valid, distance, overflow, output ready);
endinterface

@@ rtl/fixed_point_hypot_iterative.sv @@
// Top level of the iterative fixed-point hypotenuse block.
// One transfer in produces one result transfer out. Each item runs up to MAX_PASSES
// reflection passes on one shared shift-subtract divider (two divisions per pass) and one
// 32x32 multiplier (three products per pass). The check after the first division and the
// squaring ends the iteration early when the squared ratio is zero. An item that is zero
// or out of range goes straight from idle to the result state, which holds until taken.
// The input is not ready while an item is in progress or its result waits to be taken.
module fixed_point_hypot_iterative (
	input logic clk,
	input logic arst_n,
	fph_in_if.sink in_ch,
	fph_out_if.source out_ch
);
	import fph_pkg::*;

	state_t state_q, state_d;
	logic [31:0] big_q, small_q, r_q;
	logic [PASS_W-1:0] pass_q;
	logic [47:0] quo_q;
	logic [31:0] den_q;
	logic [32:0] rem_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [30:0] dist_q;
	logic ovf_q;
	logic [31:0] mag_a, mag_b, mx, mn;
	logic [63:0] prod;
	logic [31:0] mul_x, mul_y;
	logic [32:0] rem_sh, rem_sub;
	logic div_last;

	assign mag_a = in_ch.first_value[31] ? (~in_ch.first_value + 32'd1) : in_ch.first_value;
	assign mag_b = in_ch.second_value[31] ? (~in_ch.second_value + 32'd1) : in_ch.second_value;
	assign mx = (mag_a < mag_b) ? mag_b : mag_a;
	assign mn = (mag_a < mag_b) ? mag_a : mag_b;

	always_comb begin
		mul_x = r_q;
		mul_y = r_q;
		case (state_q)
			ST_SQ: begin
				mul_x = quo_q[31:0];
				mul_y = quo_q[31:0];
			end
			ST_MUL_A: begin
				mul_x = big_q;
				mul_y = quo_q[31:0];
			end
			ST_MUL_B: begin
				mul_x = small_q;
				mul_y = r_q;
			end
			default: begin
			end
		endcase
	end
	assign prod = 64'(mul_x) * 64'(mul_y);

	assign rem_sh = {rem_q[31:0], quo_q[47]};
	assign rem_sub = rem_sh - {1'b0, den_q};
	assign div_last = (cnt_q == DIV_CNT_W'(DIV_STEPS - 1));

	always_comb begin
		state_d = state_q;
		in_ch.ready = (state_q == ST_IDLE);
		case (state_q)
			ST_IDLE: if (in_ch.valid) state_d = (mx > LIMIT_MAG || mx == 32'd0) ? ST_DONE : ST_DIV1;
			ST_DIV1: if (div_last) state_d = ST_SQ;
			ST_SQ: state_d = ST_CHK;
			ST_CHK: state_d = (r_q == 32'd0) ? ST_DONE : ST_DIV2;
			ST_DIV2: if (div_last) state_d = ST_MUL_A;
			ST_MUL_A: state_d = ST_MUL_B;
			ST_MUL_B: state_d = (pass_q == PASS_W'(MAX_PASSES - 1)) ? ST_DONE : ST_DIV1;
			ST_DONE: if (out_ch.ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				big_q <= mx;
				small_q <= mn;
				pass_q <= '0;
				cnt_q <= '0;
				rem_q <= '0;
				quo_q <= {mn, 16'd0};
				den_q <= mx;
				ovf_q <= (mx > LIMIT_MAG);
				dist_q <= (mx > LIMIT_MAG) ? 31'd0 : mx[30:0];
			end
			ST_DIV1, ST_DIV2: begin
				cnt_q <= cnt_q + DIV_CNT_W'(1);
				if (!rem_sub[32]) begin
					rem_q <= rem_sub;
					quo_q <= {quo_q[46:0], 1'b1};
				end else begin
					rem_q <= rem_sh;
					quo_q <= {quo_q[46:0], 1'b0};
				end
			end
			ST_SQ: r_q <= prod[47:16];
			ST_CHK: begin
				cnt_q <= '0;
				rem_q <= '0;
				quo_q <= {r_q, 16'd0};
				den_q <= r_q + FOUR_FIX;
			end
			ST_MUL_A: begin
				r_q <= quo_q[31:0];
				big_q <= big_q + prod[46:15];
			end
			ST_MUL_B: begin
				pass_q <= pass_q + PASS_W'(1);
				cnt_q <= '0;
				rem_q <= '0;
				quo_q <= {prod[47:16], 16'd0};
				den_q <= big_q;
				small_q <= prod[47:16];
			end
			default: begin
			end
		endcase
		if (state_q == ST_CHK && r_q == 32'd0) dist_q <= big_q[30:0];
		if (state_q == ST_MUL_B) dist_q <= big_q[30:0];
	end

	assign out_ch.valid = (state_q == ST_DONE);
	assign out_ch.distance = dist_q;
	assign out_ch.overflow = ovf_q;
endmodule

@@ rtl/fph_checker.sv @@
// Port-level checker for the hypotenuse block and its bind.
module fph_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [30:0] distance,
	input logic overflow
);
	a_excl: assert property (@(posedge clk) disable iff (!arst_n) !(in_ready && out_valid))
		else $error("input ready while result pending");
	a_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && overflow |-> distance == 31'd0) else $error("overflow with distance");
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready) else $error("ready right after transfer");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(distance))
		else $error("result dropped");
endmodule

bind fixed_point_hypot_iterative fph_checker u_fph_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.distance(out_ch.distance), .overflow(out_ch.overflow)
);

@@ dv/tb_fixed_point_hypot_iterative.sv @@
// Self-checking testbench for the iterative fixed-point hypotenuse block.
`timescale 1ns / 1ps

module tb_fixed_point_hypot_iterative;
	import fph_pkg::*;

	typedef struct {
		logic [30:0] distance;
		logic overflow;
	} hypot_t;

	typedef struct {
		logic [31:0] a;
		logic [31:0] b;
		logic known;
		logic [30:0] distance;
		logic overflow;
	} row_t;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int RANDOM_ITEMS = 1500;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	fph_in_if in_ch();
	fph_out_if out_ch();

	hypot_t pending_q[$];
	int fails = 0;
	int idle_cycles = 0;
	bit calm = 1'b0;
	int out_stall = 0;
	row_t rows[$];

	fixed_point_hypot_iterative DUT (.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch));

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [63:0] mag_of(logic [31:0] v);
		return v[31] ? {32'd0, (~v) + 32'd1} : {32'd0, v};
	endfunction

	function automatic logic [63:0] fmul(logic [63:0] x, logic [63:0] y);
		return (x * y) >> 16;
	endfunction

	function automatic logic [63:0] fdiv(logic [63:0] x, logic [63:0] y);
		return (y == 0) ? 64'd0 : (x << 16) / y;
	endfunction

	function automatic hypot_t predict_hypot(logic [31:0] a, logic [31:0] b);
		hypot_t r;
		logic [63:0] big, lit, t;
		big = mag_of(a);
		lit = mag_of(b);
		if (big < lit) begin
			t = big;
			big = lit;
			lit = t;
		end
		if (big > {32'd0, LIMIT_MAG}) begin
			r.distance = '0;
			r.overflow = 1'b1;
			return r;
		end
		if (big > 0) begin
			for (int p = 0; p < MAX_PASSES; p++) begin
				t = fdiv(lit, big);
				t = fmul(t, t);
				if (t == 0)
					break;
				t = fdiv(t, t + {32'd0, FOUR_FIX});
				big = big + fmul(2 * big, t);
				lit = fmul(lit, t);
			end
		end
		r.distance = big[30:0];
		r.overflow = 1'b0;
		return r;
	endfunction

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return $urandom();
			1: return $urandom_range(0, 32'h2fffffff);
			2: return -$urandom_range(0, 32'h2fffffff);
			3: return $urandom_range(0, 32'h000fffff) ^ {32{$urandom_range(0, 1) == 1}};
			4: return 32'h2fffffff + $urandom_range(0, 4) - 2;
			default: return $urandom_range(0, 32'h0000ffff);
		endcase
	endfunction

	task automatic add_row(logic [31:0] a, logic [31:0] b, logic known, logic [30:0] d,
			logic ov);
		row_t r;
		r.a = a;
		r.b = b;
		r.known = known;
		r.distance = d;
		r.overflow = ov;
		rows.push_back(r);
	endtask

	task automatic send_item(logic [31:0] a, logic [31:0] b);
		hypot_t e;
		in_ch.valid <= 1'b1;
		in_ch.first_value <= a;
		in_ch.second_value <= b;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		e = predict_hypot(a, b);
		pending_q.push_back(e);
		if (!calm && $urandom_range(0, 3) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
			if (out_ch.valid && out_ch.ready) begin
				if (pending_q.size() == 0) begin
					$error("unexpected result transfer distance %h", out_ch.distance);
					fails++;
				end else begin
					hypot_t e;
					e = pending_q.pop_front();
					if (out_ch.distance !== e.distance) begin
						$error("distance expected %h actual %h", e.distance, out_ch.distance);
						fails++;
					end
					if (out_ch.overflow !== e.overflow) begin
						$error("overflow expected %b actual %b", e.overflow, out_ch.overflow);
						fails++;
					end
				end
			end
			if (out_stall > 0) begin
				out_stall <= out_stall - 1;
				out_ch.ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				out_stall <= $urandom_range(0, 5);
				out_ch.ready <= 1'b0;
			end else
				out_ch.ready <= 1'b1;
		end
	end

	initial begin
		int wait_cycles;
		in_ch.valid = 1'b0;
		in_ch.first_value = '0;
		in_ch.second_value = '0;
		out_ch.ready = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		add_row(32'h0, 32'h0, 1'b1, 31'h0, 1'b0);
		add_row(32'h80000000, 32'h0, 1'b1, 31'h0, 1'b1);
		add_row(32'h0, 32'h80000000, 1'b1, 31'h0, 1'b1);
		add_row(32'h80000000, 32'h80000000, 1'b1, 31'h0, 1'b1);
		add_row(32'h30000000, 32'h0, 1'b1, 31'h0, 1'b1);
		add_row(32'h7fffffff, 32'h1, 1'b1, 31'h0, 1'b1);
		add_row(32'h1, 32'hd0000000, 1'b1, 31'h0, 1'b1);
		add_row(32'h2fffffff, 32'h0, 1'b1, 31'h2fffffff, 1'b0);
		add_row(32'hd0000001, 32'h0, 1'b1, 31'h2fffffff, 1'b0);
		add_row(32'h00010000, 32'h0, 1'b1, 31'h00010000, 1'b0);
		add_row(32'h0, 32'hffff0000, 1'b1, 31'h00010000, 1'b0);
		add_row(32'h1, 32'h0, 1'b1, 31'h1, 1'b0);
		add_row(32'h2fffffff, 32'h2fffffff, 1'b0, '0, 1'b0);
		add_row(32'hd0000001, 32'h2fffffff, 1'b0, '0, 1'b0);
		add_row(32'h00030000, 32'h00040000, 1'b0, '0, 1'b0);
		add_row(32'hfffd0000, 32'hfffc0000, 1'b0, '0, 1'b0);
		add_row(32'h00010000, 32'h00010000, 1'b0, '0, 1'b0);
		add_row(32'h1, 32'h1, 1'b0, '0, 1'b0);
		add_row(32'h7fffffff, 32'h7fffffff, 1'b0, '0, 1'b0);
		add_row(32'h00000001, 32'h2fffffff, 1'b0, '0, 1'b0);
		add_row(32'h12345678, 32'h00000100, 1'b0, '0, 1'b0);

		foreach (rows[i]) begin
			if (rows[i].known) begin
				hypot_t p;
				p = predict_hypot(rows[i].a, rows[i].b);
				if (p.distance !== rows[i].distance || p.overflow !== rows[i].overflow) begin
					$error("table row %0d: distance expected %h actual %h", i,
						rows[i].distance, p.distance);
					fails++;
				end
			end
			send_item(rows[i].a, rows[i].b);
		end

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == RANDOM_ITEMS - 150)
				calm = 1'b1;
			send_item(rand_coord(), rand_coord());
		end
		in_ch.valid <= 1'b0;

		wait_cycles = 0;
		while (pending_q.size() != 0 && wait_cycles < 4 * WATCHDOG_LIMIT) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (1000) @(posedge clk);
		if (fails == 0 && pending_q.size() == 0)
			$display("SUCCESS");
		else begin
			if (pending_q.size() != 0)
				$error("%0d results never arrived", pending_q.size());
			$display("FAILURE");
		end
		$finish;
	end
endmodule
